/* hw/rtl/swtg_pkg.sv */
// Shared types and constants for the square-wave tone generator.
package swtg_pkg;

   localparam int FREQ_W   = 16;
   localparam int DUR_W    = 16;
   localparam int PHASE_W  = 16;
   localparam int CNT_W    = 22;
   localparam int AMP_W    = 15;
   localparam int SAMPLE_W = 16;
   localparam int CMD_W    = 2;

   localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(16000);
   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   // Milliseconds per second, and the bits its remainder needs.
   localparam int MS_PER_S  = 1000;
   localparam int MS_FRAC_W = $clog2(MS_PER_S);

   typedef enum logic [CMD_W-1:0] {
      CMD_PLAY = 2'd0,
      CMD_STOP = 2'd1,
      CMD_TICK = 2'd2
   } cmd_type;

   // One command after the arithmetic front end: increment and count precomputed.
   typedef struct packed {
      cmd_type             cmd;
      logic [FREQ_W-1:0]   freq;
      logic [PHASE_W-1:0]  inc;
      logic [CNT_W-1:0]    cnt;
   } item_type;

endpackage

/* hw/rtl/swtg_ifs.sv */
// Valid/ready channel interfaces for commands, samples and the amplitude register.
interface swtg_req_if;
   logic                        valid;
   logic                        ready;
   logic [swtg_pkg::CMD_W-1:0]  cmd;
   logic [swtg_pkg::FREQ_W-1:0] tone_freq;
   logic [swtg_pkg::DUR_W-1:0]  duration_ms;

   modport source (output valid, cmd, tone_freq, duration_ms, input ready);
   modport sink   (input valid, cmd, tone_freq, duration_ms, output ready);
endinterface

interface swtg_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [swtg_pkg::SAMPLE_W-1:0] sample;
   logic                                 tone_active;

   modport source (output valid, sample, tone_active, input ready);
   modport sink   (input valid, sample, tone_active, output ready);
endinterface

interface swtg_csr_if;
   logic                       valid;
   logic                       ready;
   logic [swtg_pkg::AMP_W-1:0] amplitude;

   modport source (output valid, amplitude, input ready);
   modport sink   (input valid, amplitude, output ready);
endinterface

/* hw/rtl/swtg_prep.sv */
// Arithmetic front end: phase increment and sample count from each command's fields.
module swtg_prep #(
   parameter int AUDIO_RATE = 44100
) (
   input  logic                   clock,
   input  logic                   reset,
   swtg_req_if.sink               req,
   output logic                   item_valid,
   input  logic                   item_ready,
   output swtg_pkg::item_type     item
);

   localparam int FREQ_W  = swtg_pkg::FREQ_W;
   localparam int DUR_W   = swtg_pkg::DUR_W;
   localparam int PHASE_W = swtg_pkg::PHASE_W;
   localparam int CNT_W   = swtg_pkg::CNT_W;
   localparam int NUM_W   = FREQ_W + PHASE_W;
   localparam int SR_W    = $clog2(AUDIO_RATE + 1);

   // freq * 2^PHASE_W / rate via a reciprocal scaled by 2^NUM_W; off by at most one.
   localparam longint unsigned INC_RECIP = (64'd1 << NUM_W) / AUDIO_RATE;
   localparam int RECIP_W = $clog2(INC_RECIP + 1);
   localparam int FP_W    = FREQ_W + RECIP_W;
   localparam int FQS_W   = RECIP_W + SR_W;

   // dur * rate / 1000 = dur * whole_khz + (dur * frac) / 1000.
   localparam int RATE_KHZ  = AUDIO_RATE / swtg_pkg::MS_PER_S;
   localparam int RATE_FRAC = AUDIO_RATE % swtg_pkg::MS_PER_S;
   localparam int KHZ_W     = $clog2(RATE_KHZ + 1);
   localparam int DB_W      = DUR_W + KHZ_W;
   localparam int DY_W      = DUR_W + swtg_pkg::MS_FRAC_W;
   localparam longint unsigned DIV_RECIP = (64'd1 << DY_W) / swtg_pkg::MS_PER_S;
   localparam int DRECIP_W  = $clog2(DIV_RECIP + 1);
   localparam int DP_W      = DY_W + DRECIP_W;
   localparam int DQS_W     = DRECIP_W + swtg_pkg::MS_FRAC_W;
   localparam int RAW_W     = DUR_W + SR_W;

   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

   logic                  s1_valid_ff;
   swtg_pkg::cmd_type     s1_cmd_ff;
   logic [FREQ_W-1:0]     s1_freq_ff;
   logic [DUR_W-1:0]      s1_dur_ff;

   logic                  s2_valid_ff;
   swtg_pkg::cmd_type     s2_cmd_ff;
   logic [FREQ_W-1:0]     s2_freq_ff;
   logic [DUR_W-1:0]      s2_dur_ff;
   logic [FP_W-1:0]       s2_fp_in, s2_fp_ff;
   logic [DY_W-1:0]       s2_dy_in, s2_dy_ff;

   logic                  s3_valid_ff;
   swtg_pkg::cmd_type     s3_cmd_ff;
   logic [FREQ_W-1:0]     s3_freq_ff;
   logic [DUR_W-1:0]      s3_dur_ff;
   logic [DY_W-1:0]       s3_dy_ff;
   logic [RECIP_W-1:0]    s3_fq_in, s3_fq_ff;
   logic [FQS_W-1:0]      s3_fqs_in, s3_fqs_ff;
   logic [DP_W-1:0]       s3_dp_in, s3_dp_ff;

   logic                  s4_valid_ff;
   swtg_pkg::cmd_type     s4_cmd_ff;
   logic [FREQ_W-1:0]     s4_freq_ff;
   logic [DUR_W-1:0]      s4_dur_ff;
   logic [DY_W-1:0]       s4_dy_ff;
   logic [NUM_W-1:0]      inc_num, inc_rem;
   logic                  inc_corr;
   logic [PHASE_W-1:0]    s4_inc_in, s4_inc_ff;
   logic [DRECIP_W-1:0]   s4_dq_in, s4_dq_ff;
   logic [DQS_W-1:0]      s4_dqs_in, s4_dqs_ff;
   logic [DB_W-1:0]       s4_dbase_in, s4_dbase_ff;

   logic                  s5_valid_ff;
   swtg_pkg::cmd_type     s5_cmd_ff;
   logic [FREQ_W-1:0]     s5_freq_ff;
   logic [DUR_W-1:0]      s5_dur_ff;
   logic [PHASE_W-1:0]    s5_inc_ff;
   logic [DY_W-1:0]       dur_rem;
   logic                  dur_corr;
   logic [RAW_W-1:0]      s5_raw_in, s5_raw_ff;

   logic                  s6_valid_ff;
   logic [CNT_W-1:0]      s6_cnt_in;
   swtg_pkg::item_type    s6_item_ff;

   // Each stage moves when it is empty or the stage after it moves.
   assign rdy6      = !s6_valid_ff || item_ready;
   assign rdy5      = !s5_valid_ff || rdy6;
   assign rdy4      = !s4_valid_ff || rdy5;
   assign rdy3      = !s3_valid_ff || rdy4;
   assign rdy2      = !s2_valid_ff || rdy3;
   assign rdy1      = !s1_valid_ff || rdy2;
   assign req.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff <= req.valid;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
         if (rdy3) s3_valid_ff <= s2_valid_ff;
         if (rdy4) s4_valid_ff <= s3_valid_ff;
         if (rdy5) s5_valid_ff <= s4_valid_ff;
         if (rdy6) s6_valid_ff <= s5_valid_ff;
      end
   end

   // Stage 2: reciprocal products.
   assign s2_fp_in = FP_W'(s1_freq_ff) * FP_W'(INC_RECIP);
   assign s2_dy_in = DY_W'(s1_dur_ff) * DY_W'(RATE_FRAC);

   // Stage 3: quotient estimates and the back-multiply for the increment.
   assign s3_fq_in  = RECIP_W'(s2_fp_ff >> FREQ_W);
   assign s3_fqs_in = FQS_W'(s3_fq_in) * FQS_W'(AUDIO_RATE);
   assign s3_dp_in  = DP_W'(s2_dy_ff) * DP_W'(DIV_RECIP);

   // Stage 4: correct the increment, back-multiply the duration fraction.
   assign inc_num     = {s3_freq_ff, {PHASE_W{1'b0}}};
   assign inc_rem     = inc_num - NUM_W'(s3_fqs_ff);
   assign inc_corr    = inc_rem >= NUM_W'(AUDIO_RATE);
   assign s4_inc_in   = PHASE_W'(s3_fq_ff) + PHASE_W'(inc_corr);
   assign s4_dq_in    = DRECIP_W'(s3_dp_ff >> DY_W);
   assign s4_dqs_in   = DQS_W'(s4_dq_in) * DQS_W'(swtg_pkg::MS_PER_S);
   assign s4_dbase_in = DB_W'(s3_dur_ff) * DB_W'(RATE_KHZ);

   // Stage 5: correct the fraction and add the whole-kHz part.
   assign dur_rem   = s4_dy_ff - DY_W'(s4_dqs_ff);
   assign dur_corr  = dur_rem >= DY_W'(swtg_pkg::MS_PER_S);
   assign s5_raw_in = RAW_W'(s4_dbase_ff) + RAW_W'(s4_dq_ff) + RAW_W'(dur_corr);

   // Stage 6: zero means endless, else at least one sample, saturated to the counter.
   always_comb begin
      if (s5_dur_ff == '0) begin
         s6_cnt_in = '0;
      end else if (s5_raw_ff == '0) begin
         s6_cnt_in = CNT_W'(1);
      end else if (s5_raw_ff > RAW_W'(swtg_pkg::COUNT_MAX)) begin
         s6_cnt_in = swtg_pkg::COUNT_MAX;
      end else begin
         s6_cnt_in = CNT_W'(s5_raw_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_cmd_ff  <= swtg_pkg::cmd_type'(req.cmd);
         s1_freq_ff <= req.tone_freq;
         s1_dur_ff  <= req.duration_ms;
      end
      if (rdy2) begin
         s2_cmd_ff  <= s1_cmd_ff;
         s2_freq_ff <= s1_freq_ff;
         s2_dur_ff  <= s1_dur_ff;
         s2_fp_ff   <= s2_fp_in;
         s2_dy_ff   <= s2_dy_in;
      end
      if (rdy3) begin
         s3_cmd_ff  <= s2_cmd_ff;
         s3_freq_ff <= s2_freq_ff;
         s3_dur_ff  <= s2_dur_ff;
         s3_dy_ff   <= s2_dy_ff;
         s3_fq_ff   <= s3_fq_in;
         s3_fqs_ff  <= s3_fqs_in;
         s3_dp_ff   <= s3_dp_in;
      end
      if (rdy4) begin
         s4_cmd_ff   <= s3_cmd_ff;
         s4_freq_ff  <= s3_freq_ff;
         s4_dur_ff   <= s3_dur_ff;
         s4_dy_ff    <= s3_dy_ff;
         s4_inc_ff   <= s4_inc_in;
         s4_dq_ff    <= s4_dq_in;
         s4_dqs_ff   <= s4_dqs_in;
         s4_dbase_ff <= s4_dbase_in;
      end
      if (rdy5) begin
         s5_cmd_ff  <= s4_cmd_ff;
         s5_freq_ff <= s4_freq_ff;
         s5_dur_ff  <= s4_dur_ff;
         s5_inc_ff  <= s4_inc_ff;
         s5_raw_ff  <= s5_raw_in;
      end
      if (rdy6) begin
         s6_item_ff.cmd  <= s5_cmd_ff;
         s6_item_ff.freq <= s5_freq_ff;
         s6_item_ff.inc  <= s5_inc_ff;
         s6_item_ff.cnt  <= s6_cnt_in;
      end
   end

   assign item_valid = s6_valid_ff;
   assign item       = s6_item_ff;

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rdy2) |=> (s1_valid_ff && $stable(s1_freq_ff) && $stable(s1_dur_ff)))
      else $error("stage 1 item lost or changed while stalled");

   a_inc_estimate: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (inc_rem < NUM_W'(2 * AUDIO_RATE)))
      else $error("phase increment estimate off by more than one");

   a_dur_estimate: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> (dur_rem < DY_W'(2 * swtg_pkg::MS_PER_S)))
      else $error("duration quotient estimate off by more than one");

endmodule

/* hw/rtl/swtg_core.sv */
// Tone state (frequency, phase, countdown) and the sample output register.
module swtg_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_valid,
   output logic                         item_ready,
   input  swtg_pkg::item_type           item,
   input  logic [swtg_pkg::AMP_W-1:0]   amplitude,
   swtg_rsp_if.source                   rsp
);

   localparam int FREQ_W   = swtg_pkg::FREQ_W;
   localparam int PHASE_W  = swtg_pkg::PHASE_W;
   localparam int CNT_W    = swtg_pkg::CNT_W;
   localparam int SAMPLE_W = swtg_pkg::SAMPLE_W;

   logic                       item_fire;
   logic                       tick_fire;

   logic [FREQ_W-1:0]          freq_in, freq_ff;
   logic [CNT_W-1:0]           count_in, count_ff;
   logic [PHASE_W-1:0]         phase_in, phase_ff;
   logic [PHASE_W-1:0]         inc_in, inc_ff;

   logic                       emit;
   logic signed [SAMPLE_W-1:0] level;
   logic signed [SAMPLE_W-1:0] sample_in, sample_ff;
   logic                       active_in, active_ff;
   logic                       rsp_valid_ff;

   // Only a tick needs the output register; other commands pass while it is full.
   assign item_ready = !(item_valid && (item.cmd == swtg_pkg::CMD_TICK)
                         && rsp_valid_ff && !rsp.ready);
   assign item_fire  = item_valid && item_ready;
   assign tick_fire  = item_fire && (item.cmd == swtg_pkg::CMD_TICK);

   assign level = $signed(SAMPLE_W'(amplitude));

   always_comb begin
      freq_in   = freq_ff;
      count_in  = count_ff;
      phase_in  = phase_ff;
      inc_in    = inc_ff;
      emit      = 1'b0;
      sample_in = '0;
      active_in = 1'b0;
      if (item_fire) begin
         unique case (item.cmd)
            swtg_pkg::CMD_PLAY: begin
               freq_in  = item.freq;
               count_in = item.cnt;
               phase_in = '0;
               inc_in   = item.inc;
            end
            swtg_pkg::CMD_STOP: begin
               freq_in = '0;
            end
            swtg_pkg::CMD_TICK: begin
               emit = 1'b1;
               if (freq_ff != '0) begin
                  active_in = 1'b1;
                  sample_in = phase_ff[PHASE_W-1] ? -level : level;
                  phase_in  = phase_ff + inc_ff;
                  if (count_ff != '0) begin
                     count_in = count_ff - CNT_W'(1);
                     if (count_ff == CNT_W'(1)) begin
                        freq_in = '0;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff      <= '0;
         count_ff     <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         freq_ff  <= freq_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      inc_ff <= inc_in;
      if (emit) begin
         sample_ff <= sample_in;
         active_ff <= active_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.sample      = sample_ff;
   assign rsp.tone_active = active_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      tick_fire |-> (!rsp_valid_ff || rsp.ready))
      else $error("tick result overwrote an untaken sample");

   a_count_expiry: assert property (@(posedge clock) disable iff (reset)
      (tick_fire && (freq_ff != '0) && (count_ff == CNT_W'(1))) |=> (freq_ff == '0))
      else $error("tone kept sounding after its last sample");

   a_phase_moves: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != $past(phase_ff)) |-> $past(item_fire))
      else $error("phase changed without a command");

endmodule

/* hw/rtl/square_wave_tone_generator.sv */
// Square-wave tone generator top level: amplitude register, front end and tone core.
//
// Buzzer-style tone source built on a 16-bit phase accumulator. Each transfer on req
// carries one command: play (load tone_freq, clear the phase and start a countdown of
// duration_ms * AUDIO_RATE / 1000 samples, at least one, with a duration of zero
// playing until stopped), stop (silence the tone, keep phase and count) or tick (emit
// one sample on rsp: +amplitude while the phase is in its lower half, -amplitude in
// its upper half, 0 when silent). Command code 3 is dropped without a result. The
// block takes one command per clock cycle unless a tick is held behind an untaken
// sample; a tick's transfer loads the first of the six stages of the arithmetic front
// end (the phase increment and sample count are divided by constants through
// reciprocal multiplies with a one-step correction), and the output register loads
// from the last stage after the tick has passed through all six. Up to six commands
// sit in the front end while a finished sample waits on rsp, so req keeps taking
// transfers until that front end is full; play and stop complete while a sample
// waits, ticks hold. The amplitude register on csr is always ready and resets to
// 16000; write it only while no command is in flight.
module square_wave_tone_generator #(
   parameter int AUDIO_RATE = 44100
) (
   input  logic        clock,
   input  logic        reset,
   swtg_req_if.sink    req,
   swtg_rsp_if.source  rsp,
   swtg_csr_if.sink    csr
);

   logic [swtg_pkg::AMP_W-1:0] amp_ff;
   logic                       item_valid;
   logic                       item_ready;
   swtg_pkg::item_type         item;

   // Amplitude register: take every csr transfer.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff <= swtg_pkg::AMP_RESET;
      end else if (csr.valid) begin
         amp_ff <= csr.amplitude;
      end
   end

   // Precompute the phase increment and sample count for every command.
   swtg_prep #(
      .AUDIO_RATE (AUDIO_RATE)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   // Apply commands to the tone state and hold tick results for rsp.
   swtg_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .amplitude  (amp_ff),
      .rsp        (rsp)
   );

endmodule

/* dv/tb_square_wave_tone_generator.sv */
// Self-checking testbench for the square-wave tone generator.
module tb_square_wave_tone_generator;

   timeunit 1ns;
   timeprecision 1ps;

   // Sample rate the block is built for; the predictor divides by the same value.
   localparam int RATE           = 44100;
   // Command code that the block must drop without a result.
   localparam logic [swtg_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   // Margin for commands that still pass through the front end after the last result.
   localparam int DRAIN_CYCLES   = 16;
   // Longest stretch with no transfer on any channel before the run is declared hung.
   localparam int QUIET_LIMIT    = 5000;
   // Long receiver hold-off used to fill the front end.
   localparam int HOLD_CYCLES    = 300;
   localparam int PRINT_LIMIT    = 40;
   localparam logic [swtg_pkg::PHASE_W-1:0] HALF_PHASE = 16'h8000;

   typedef struct packed {
      logic signed [swtg_pkg::SAMPLE_W-1:0] sample;
      logic                                 tone_active;
   } sample_type;

   logic clock;
   logic reset;

   swtg_req_if req_if ();
   swtg_rsp_if rsp_if ();
   swtg_csr_if csr_if ();

   square_wave_tone_generator #(
      .AUDIO_RATE (RATE)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source),
      .csr   (csr_if.sink)
   );

   // Predictor copy of the block's state and its one register.
   logic [swtg_pkg::AMP_W-1:0]   level;
   logic [swtg_pkg::FREQ_W-1:0]  tone_freq;
   logic [swtg_pkg::CNT_W-1:0]   samples_left;
   logic [swtg_pkg::PHASE_W-1:0] phase_acc;

   sample_type  pending_samples[$];
   int unsigned mismatch_count;
   int unsigned quiet_cycles;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_request;
   int unsigned hold_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Print one line per mismatch (up to a cap) and count every one.
   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   // Apply one accepted command to the predicted state; a tick queues its sample.
   task automatic predict_tone_step(input logic [swtg_pkg::CMD_W-1:0] cmd,
                                    input logic [swtg_pkg::FREQ_W-1:0] freq,
                                    input logic [swtg_pkg::DUR_W-1:0] dur_ms);
      longint unsigned count;
      longint unsigned step;
      sample_type      out;
      case (cmd)
         swtg_pkg::CMD_PLAY: begin
            count = 0;
            if (dur_ms != 0) begin
               count = longint'(dur_ms) * RATE / swtg_pkg::MS_PER_S;
               // Short tones still last at least one sample; long ones clamp.
               if (count == 0) count = 1;
               if (count > swtg_pkg::COUNT_MAX) count = swtg_pkg::COUNT_MAX;
            end
            tone_freq    = freq;
            samples_left = swtg_pkg::CNT_W'(count);
            phase_acc    = '0;
         end
         swtg_pkg::CMD_STOP: begin
            // Silence only; phase and countdown survive.
            tone_freq = '0;
         end
         swtg_pkg::CMD_TICK: begin
            out.sample      = '0;
            out.tone_active = 1'b0;
            if (tone_freq != 0) begin
               out.tone_active = 1'b1;
               out.sample      = swtg_pkg::SAMPLE_W'(level);
               if (phase_acc >= HALF_PHASE) out.sample = -out.sample;
               step      = longint'(tone_freq) * 65536 / RATE;
               phase_acc = phase_acc + swtg_pkg::PHASE_W'(step);
               // A zero count means endless; otherwise run down and go silent at zero.
               if (samples_left != 0) begin
                  samples_left = samples_left - 1'b1;
                  if (samples_left == 0) tone_freq = '0;
               end
            end
            pending_samples.push_back(out);
         end
         default: begin
            // Unused code: no result, no state change.
         end
      endcase
   endtask

   // Observe all three channels at each edge: check samples, track the register,
   // predict accepted commands and count cycles without any transfer.
   always @(posedge clock) begin
      sample_type want;
      logic       moved;
      if (reset) begin
         level        = swtg_pkg::AMP_RESET;
         tone_freq    = '0;
         samples_left = '0;
         phase_acc    = '0;
         pending_samples.delete();
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            if (pending_samples.size() == 0) begin
               report_mismatch("unexpected sample", int'(rsp_if.sample), 0);
            end else begin
               want = pending_samples.pop_front();
               if (rsp_if.sample !== want.sample) begin
                  report_mismatch("sample", int'(rsp_if.sample), int'(want.sample));
               end
               if (rsp_if.tone_active !== want.tone_active) begin
                  report_mismatch("tone_active", int'(rsp_if.tone_active),
                                  int'(want.tone_active));
               end
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            moved = 1'b1;
            level = csr_if.amplitude;
         end
         if (req_if.valid && req_if.ready) begin
            moved = 1'b1;
            predict_tone_step(req_if.cmd, req_if.tone_freq, req_if.duration_ms);
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // Receiver: random stalls, plus a long hold-off when a test asks for one.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: end the run when no channel has moved for too long.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
   end

   // Offer one command, with random gaps ahead of it, and hold it until the transfer.
   task automatic send_cmd(input logic [swtg_pkg::CMD_W-1:0] cmd,
                           input logic [swtg_pkg::FREQ_W-1:0] freq,
                           input logic [swtg_pkg::DUR_W-1:0] dur_ms);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.cmd         <= cmd;
      req_if.tone_freq   <= freq;
      req_if.duration_ms <= dur_ms;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Drop valid and wait until every queued sample has been received.
   task automatic wait_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_samples.size() != 0) @(posedge clock);
   endtask

   // Results are in, but plays and stops may still sit in the front end.
   task automatic wait_until_quiet();
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_amplitude(input logic [swtg_pkg::AMP_W-1:0] value);
      wait_until_quiet();
      csr_if.valid     <= 1'b1;
      csr_if.amplitude <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Field extremes, every command and the corner behaviors, at reset amplitude.
   task automatic test_directed_commands();
      send_cmd(swtg_pkg::CMD_TICK, '0, '0);                 // silent after reset
      send_cmd(CMD_UNUSED, '1, '1);                         // dropped, no result
      send_cmd(swtg_pkg::CMD_TICK, '1, '1);
      send_cmd(swtg_pkg::CMD_PLAY, 16'd22050, '0);          // half-period step, endless
      repeat (4) send_cmd(swtg_pkg::CMD_TICK, '0, '0);
      send_cmd(swtg_pkg::CMD_STOP, '1, '1);
      send_cmd(swtg_pkg::CMD_TICK, '0, '0);                 // silent, phase kept
      send_cmd(swtg_pkg::CMD_PLAY, '0, 16'd5);              // rest with a duration
      repeat (2) send_cmd(swtg_pkg::CMD_TICK, '0, '0);
      send_cmd(swtg_pkg::CMD_PLAY, '1, '1);                 // top frequency, longest tone
      repeat (3) send_cmd(swtg_pkg::CMD_TICK, 16'h5555, 16'hAAAA);
      send_cmd(swtg_pkg::CMD_PLAY, 16'd1, 16'd1);           // smallest step, shortest tone
      repeat (2) send_cmd(swtg_pkg::CMD_TICK, 16'hAAAA, 16'h5555);
      send_cmd(swtg_pkg::CMD_STOP, '0, '0);
   endtask

   // Register extremes: zero level, full level and one.
   task automatic test_amplitude_extremes();
      logic [swtg_pkg::AMP_W-1:0] levels[3];
      levels = '{'1, '0, swtg_pkg::AMP_W'(1)};
      foreach (levels[i]) begin
         write_amplitude(levels[i]);
         send_cmd(swtg_pkg::CMD_PLAY, 16'd11025, '0);
         repeat (8) send_cmd(swtg_pkg::CMD_TICK, '0, '0);
      end
   endtask

   // Hold the receiver off while ticks keep coming, so the block stops taking them.
   task automatic test_output_stall();
      send_cmd(swtg_pkg::CMD_PLAY, 16'd440, '0);
      hold_request = HOLD_CYCLES;
      repeat (40) send_cmd(swtg_pkg::CMD_TICK, '0, '0);
      send_cmd(swtg_pkg::CMD_STOP, '0, '0);
      wait_results();
   endtask

   // Pause the sender mid-tone until the block has emptied, then carry on.
   task automatic test_sender_pause();
      send_cmd(swtg_pkg::CMD_PLAY, 16'd1000, 16'd2);
      repeat (10) send_cmd(swtg_pkg::CMD_TICK, '0, '0);
      wait_results();
      repeat (10) send_cmd(swtg_pkg::CMD_TICK, '0, '0);
      send_cmd(swtg_pkg::CMD_STOP, '0, '0);
   endtask

   // Mostly well-formed tones (play, then a run of ticks that often outlasts the
   // countdown), with stops and random commands mixed in.
   task automatic test_random_traffic(input int unsigned n_items);
      int unsigned                   sent;
      int unsigned                   n_ticks;
      int unsigned                   pick;
      logic [swtg_pkg::FREQ_W-1:0]   freq;
      logic [swtg_pkg::DUR_W-1:0]    dur_ms;
      logic [swtg_pkg::CMD_W-1:0]    cmd;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 80) begin
            pick = $urandom_range(99);
            if (pick < 5)       freq = '0;
            else if (pick < 20) freq = swtg_pkg::FREQ_W'($urandom);
            else                freq = swtg_pkg::FREQ_W'($urandom_range(20, 20000));
            pick = $urandom_range(99);
            if (pick < 20)      dur_ms = '0;
            else if (pick < 80) dur_ms = swtg_pkg::DUR_W'($urandom_range(1, 3));
            else if (pick < 95) dur_ms = swtg_pkg::DUR_W'($urandom_range(4, 50));
            else                dur_ms = swtg_pkg::DUR_W'($urandom);
            send_cmd(swtg_pkg::CMD_PLAY, freq, dur_ms);
            sent++;
            n_ticks = $urandom_range(1, 140);
            repeat (n_ticks) begin
               pick = $urandom_range(99);
               if (pick < 2) begin
                  send_cmd(swtg_pkg::CMD_STOP, swtg_pkg::FREQ_W'($urandom),
                           swtg_pkg::DUR_W'($urandom));
                  sent++;
               end else if (pick < 3) begin
                  send_cmd(CMD_UNUSED, swtg_pkg::FREQ_W'($urandom),
                           swtg_pkg::DUR_W'($urandom));
               end else begin
                  send_cmd(swtg_pkg::CMD_TICK, swtg_pkg::FREQ_W'($urandom),
                           swtg_pkg::DUR_W'($urandom));
                  sent++;
               end
            end
         end else begin
            cmd = swtg_pkg::CMD_W'($urandom_range(3));
            send_cmd(cmd, swtg_pkg::FREQ_W'($urandom), swtg_pkg::DUR_W'($urandom));
            if (cmd != CMD_UNUSED) sent++;
         end
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.cmd         <= swtg_pkg::CMD_PLAY;
      req_if.tone_freq   <= '0;
      req_if.duration_ms <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.amplitude   <= '0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      hold_request   = 0;
      hold_left      = 0;
      send_idle_pct  = 13;
      recv_idle_pct  = 59;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender idles rarely, receiver often.
      test_directed_commands();
      test_amplitude_extremes();
      write_amplitude(swtg_pkg::AMP_W'($urandom));
      test_random_traffic(500);

      // Swap: sender idles often, receiver rarely.
      wait_until_quiet();
      send_idle_pct = 59;
      recv_idle_pct = 13;
      write_amplitude(swtg_pkg::AMP_W'($urandom));
      test_sender_pause();
      test_random_traffic(500);

      // No idling on either side.
      wait_until_quiet();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_amplitude('1);
      test_output_stall();
      write_amplitude(swtg_pkg::AMP_W'($urandom));
      test_random_traffic(500);

      // Let everything still in flight come out before judging.
      wait_until_quiet();
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
